// File: rtl/rmb_pkg.sv
// ----------------------------------------------------------------------------
// rmb_pkg
// Shared types and codes of the multichannel rewind ring buffer.
// ----------------------------------------------------------------------------
package rmb_pkg;

   // Pointer and ring length widths (ring length is at most 4096)
   localparam int PTR_W = 12;
   localparam int LEN_W = 13;

   // Operation codes on the request channel
   localparam logic [2:0] OP_WRITE     = 3'd0;
   localparam logic [2:0] OP_READ      = 3'd1;
   localparam logic [2:0] OP_SEEK_RD   = 3'd2;
   localparam logic [2:0] OP_SEEK_WR   = 3'd3;
   localparam logic [2:0] OP_SEEK_FRAC = 3'd4;

   // Q1.16 one
   localparam logic [16:0] FRAC_ONE = 17'd65536;

   // Decoded command kinds
   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_WRITE,
      CMD_READ,
      CMD_SEEK_RD,
      CMD_SEEK_WR,
      CMD_SEEK_FRAC
   } cmd_kind_type;

   typedef struct packed {
      logic [2:0]  op;
      logic        channel;
      logic [31:0] sample;
      logic        overwrite;
      logic [11:0] offset;
      logic [16:0] fraction;
      logic        burst_last;
   } req_type;

   typedef struct packed {
      logic [31:0] sample_out;
      logic        sample_valid;
      logic        write_accepted;
      logic [11:0] used_space;
      logic [11:0] free_space;
      logic [11:0] read_offset;
      logic        burst_end;
   } rsp_type;

   // Classified item as it sits in the queue
   typedef struct packed {
      cmd_kind_type kind;
      logic         bank;
      logic [31:0]  sample;
      logic         overwrite;
      logic [11:0]  offset;
      logic [16:0]  fraction;
      logic         burst_last;
   } cmd_type;

   // Queue status seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

// File: rtl/rmb_front.sv
// ----------------------------------------------------------------------------
// rmb_front
// Accepts request items, decodes the operation, saturates the fraction and
// holds the classified commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rmb_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rmb_pkg::req_type        req_data,
   input  logic                    clear_busy,
   output rmb_pkg::queue_head_type head,
   input  logic                    cmd_pop
);

   localparam int QUEUE_DEPTH = 2;

   rmb_pkg::cmd_type queue_ff [QUEUE_DEPTH];
   rmb_pkg::cmd_type queue_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   rmb_pkg::cmd_type cmd_dec;

   // Decode one request into a command
   always_comb begin
      cmd_dec.bank       = req_data.channel;
      cmd_dec.sample     = req_data.sample;
      cmd_dec.overwrite  = req_data.overwrite;
      cmd_dec.offset     = req_data.offset;
      cmd_dec.burst_last = req_data.burst_last;
      cmd_dec.fraction   = (req_data.fraction > rmb_pkg::FRAC_ONE) ?
                           rmb_pkg::FRAC_ONE : req_data.fraction;
      case (req_data.op)
         rmb_pkg::OP_WRITE:     cmd_dec.kind = rmb_pkg::CMD_WRITE;
         rmb_pkg::OP_READ:      cmd_dec.kind = rmb_pkg::CMD_READ;
         rmb_pkg::OP_SEEK_RD:   cmd_dec.kind = rmb_pkg::CMD_SEEK_RD;
         rmb_pkg::OP_SEEK_WR:   cmd_dec.kind = rmb_pkg::CMD_SEEK_WR;
         rmb_pkg::OP_SEEK_FRAC: cmd_dec.kind = rmb_pkg::CMD_SEEK_FRAC;
         default:               cmd_dec.kind = rmb_pkg::CMD_NOP;
      endcase
   end

   // Queue control
   assign req_ready = !clear_busy && (count_ff != 2'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign queue_in  = cmd_dec;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (cmd_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, cmd_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= queue_in;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = queue_ff[rd_ptr_ff];

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("queue count overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (count_ff != 2'd0))
      else $error("pop from empty queue");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'(QUEUE_DEPTH)) |-> !req_ready)
      else $error("request taken while queue full");

endmodule

// File: rtl/rmb_back.sv
// ----------------------------------------------------------------------------
// rmb_back
// Executes queued commands against the sample store and the ring pointers,
// and holds the result register. Clears the store after reset.
// ----------------------------------------------------------------------------
module rmb_back #(
   parameter int DEPTH        = 4096,
   parameter int CHANNELS     = 2,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rmb_pkg::queue_head_type head,
   output logic                    cmd_pop,
   output logic                    clear_busy,
   input  logic                    csr_wr_en,
   input  logic [11:0]             csr_wr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rmb_pkg::rsp_type        rsp_data
);

   localparam int NUM_ENTRIES = CHANNELS * DEPTH;
   localparam int IW          = $clog2(NUM_ENTRIES);
   localparam int LEN_LIMIT   = 1 << rmb_pkg::PTR_W;
   localparam int LEN_MAX_INT = (DEPTH < LEN_LIMIT) ? DEPTH : LEN_LIMIT;
   localparam logic [rmb_pkg::LEN_W-1:0] LEN_MAX = rmb_pkg::LEN_W'(LEN_MAX_INT);
   localparam int MOD_BITS    = rmb_pkg::LEN_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_MOD,
      ST_MUL,
      ST_FADD,
      ST_STAT
   } state_type;

   // Ring helpers
   function automatic logic [11:0] ring_diff(logic [11:0] a, logic [11:0] b,
                                             logic [12:0] len);
      logic [12:0] d;
      if (a >= b) begin
         d = {1'b0, a} - {1'b0, b};
      end else begin
         d = {1'b0, a} + len - {1'b0, b};
      end
      return d[11:0];
   endfunction

   function automatic logic [11:0] ring_inc(logic [11:0] p, logic [12:0] len);
      logic [12:0] n;
      n = {1'b0, p} + 13'd1;
      if (n == len) begin
         n = '0;
      end
      return n[11:0];
   endfunction

   function automatic logic [IW-1:0] mem_addr(logic bank, logic [11:0] ptr);
      if (CHANNELS > 1 && bank) begin
         return IW'(DEPTH + int'(ptr));
      end
      return IW'(ptr);
   endfunction

   state_type         state_ff, state_in;
   rmb_pkg::cmd_type  cmd_ff, cmd_in;
   logic [12:0]       len_ff, len_in;
   logic [11:0]       begin_ff, begin_in;
   logic [11:0]       end_ff, end_in;
   logic [11:0]       read_ff, read_in;
   logic [12:0]       work_ff, work_in;
   logic [12:0]       rem_ff, rem_in;
   logic [3:0]        bit_cnt_ff, bit_cnt_in;
   logic [27:0]       prod_ff, prod_in;
   logic              s_valid_ff, s_valid_in;
   logic              w_acc_ff, w_acc_in;
   logic [IW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rmb_pkg::rsp_type  rsp_ff, rsp_in;

   logic [SAMPLE_WIDTH-1:0] mem [NUM_ENTRIES];
   logic [SAMPLE_WIDTH-1:0] rdata_ff;
   logic                    mem_we;
   logic [IW-1:0]           mem_waddr;
   logic [SAMPLE_WIDTH-1:0] mem_wdata;
   logic [IW-1:0]           mem_raddr;

   logic [11:0] used_now;
   logic [12:0] space_now;
   logic [11:0] end_next;
   logic [11:0] begin_after;
   logic [11:0] read_next;
   logic [11:0] roff_now;
   logic [12:0] mod_trial;
   logic [12:0] mod_step;
   logic [12:0] frac_sum;
   logic [12:0] frac_ptr;
   logic [12:0] cap_plus;
   logic [12:0] len_cfg;

   // Datapath terms
   assign used_now    = ring_diff(end_ff, begin_ff, len_ff);
   assign space_now   = len_ff - 13'd1 - {1'b0, used_now};
   assign end_next    = ring_inc(end_ff, len_ff);
   assign begin_after = ring_inc(end_next, len_ff);
   assign read_next   = ring_inc(read_ff, len_ff);
   assign roff_now    = ring_diff(read_ff, begin_ff, len_ff);
   assign mod_trial   = {rem_ff[11:0], work_ff[12]};
   assign mod_step    = (mod_trial >= len_ff) ? mod_trial - len_ff : mod_trial;
   assign frac_sum    = {1'b0, begin_ff} + {1'b0, prod_ff[27:16]};
   assign frac_ptr    = (frac_sum >= len_ff) ? frac_sum - len_ff : frac_sum;
   assign cap_plus    = {1'b0, csr_wr_data} + 13'd1;
   assign len_cfg     = (cap_plus > LEN_MAX) ? LEN_MAX : cap_plus;

   assign mem_raddr   = mem_addr(cmd_ff.bank, read_ff);

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      begin_in     = begin_ff;
      end_in       = end_ff;
      read_in      = read_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      prod_in      = prod_ff;
      s_valid_in   = s_valid_ff;
      w_acc_in     = w_acc_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = mem_addr(cmd_ff.bank, end_ff);
      mem_wdata    = SAMPLE_WIDTH'(cmd_ff.sample);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // zero the store one entry a cycle
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + IW'(1);
            if (clr_cnt_ff == IW'(NUM_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               cmd_pop    = 1'b1;
               cmd_in     = head.cmd;
               s_valid_in = 1'b0;
               w_acc_in   = 1'b0;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff.kind)
               rmb_pkg::CMD_WRITE: begin
                  state_in = ST_STAT;
                  if (space_now != 13'd0 || cmd_ff.overwrite) begin
                     mem_we   = 1'b1;
                     end_in   = end_next;
                     w_acc_in = 1'b1;
                     if (space_now <= 13'd1) begin
                        begin_in = begin_after;
                        if (space_now == 13'd0 && read_ff == begin_ff) begin
                           read_in = begin_after;
                        end
                     end
                  end
               end
               rmb_pkg::CMD_READ: begin
                  state_in = ST_STAT;
                  if (read_ff != end_ff) begin
                     s_valid_in = 1'b1;
                     read_in    = read_next;
                  end
               end
               rmb_pkg::CMD_SEEK_RD: begin
                  work_in    = {1'b0, read_ff} + {1'b0, cmd_ff.offset};
                  rem_in     = '0;
                  bit_cnt_in = '0;
                  state_in   = ST_MOD;
               end
               rmb_pkg::CMD_SEEK_WR: begin
                  work_in    = {1'b0, end_ff} + {1'b0, cmd_ff.offset};
                  rem_in     = '0;
                  bit_cnt_in = '0;
                  state_in   = ST_MOD;
               end
               rmb_pkg::CMD_SEEK_FRAC: begin
                  work_in  = {1'b0, used_now};
                  state_in = ST_MUL;
               end
               default: begin
                  state_in = ST_STAT;
               end
            endcase
         end
         // restoring remainder, one bit a cycle, MSB first
         ST_MOD: begin
            rem_in     = mod_step;
            work_in    = {work_ff[11:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 4'd1;
            if (bit_cnt_ff == 4'(MOD_BITS - 1)) begin
               state_in = ST_STAT;
               if (cmd_ff.kind == rmb_pkg::CMD_SEEK_WR) begin
                  end_in = mod_step[11:0];
               end else begin
                  read_in = mod_step[11:0];
               end
            end
         end
         ST_MUL: begin
            prod_in  = {16'd0, work_ff[11:0]} * {11'd0, cmd_ff.fraction};
            state_in = ST_FADD;
         end
         ST_FADD: begin
            read_in  = frac_ptr[11:0];
            state_in = ST_STAT;
         end
         // status from the updated pointers into the result register
         ST_STAT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.sample_out     = s_valid_ff ? 32'(rdata_ff) : 32'd0;
               rsp_in.sample_valid   = s_valid_ff;
               rsp_in.write_accepted = w_acc_ff;
               rsp_in.used_space     = used_now;
               rsp_in.free_space     = space_now[11:0];
               rsp_in.read_offset    = roff_now;
               rsp_in.burst_end      = cmd_ff.burst_last;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capacity write restarts the ring
      if (csr_wr_en) begin
         len_in   = len_cfg;
         begin_in = '0;
         end_in   = '0;
         read_in  = '0;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         len_ff       <= LEN_MAX;
         begin_ff     <= '0;
         end_ff       <= '0;
         read_ff      <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         s_valid_ff   <= 1'b0;
         w_acc_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         begin_ff     <= begin_in;
         end_ff       <= end_in;
         read_ff      <= read_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         s_valid_ff   <= s_valid_in;
         w_acc_ff     <= w_acc_in;
      end
      cmd_ff     <= cmd_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      prod_ff    <= prod_in;
      rsp_ff     <= rsp_in;
   end

   // Sample store: one write port, one registered read port
   // read data is taken at execute and held until the result is loaded
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_EXEC) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   assign clear_busy = (state_ff == ST_CLEAR);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Checks
   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      (begin_ff < len_ff[11:0] || len_ff == 13'(LEN_LIMIT)) &&
      {1'b0, end_ff} < len_ff && {1'b0, read_ff} < len_ff &&
      {1'b0, begin_ff} < len_ff)
      else $error("ring pointer outside ring length");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) |-> (rem_ff < len_ff))
      else $error("seek remainder not reduced");

   a_stat_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STAT) |=> rsp_valid_ff)
      else $error("status step left without a result");

endmodule

// File: rtl/multichannel_rewind_ring_buffer.sv
// ----------------------------------------------------------------------------
// multichannel_rewind_ring_buffer
// Audio history ring with CHANNELS sample banks sharing begin, end and a
// rewindable read pointer; ring length is capacity+1 (limited to DEPTH).
// Each request item is one operation and yields one result item carrying the
// read sample and used space, free space and read offset after it. After
// reset the sample store is cleared one entry a cycle, all CHANNELS*DEPTH
// entries (8192 at the defaults), and no item is taken meanwhile. Items pass
// through a two-entry queue into a sequencer. Write, read and unused codes go
// through execute and status; a fraction seek adds a registered multiply and
// an add, a read or write seek the 13-step remainder reducing the new pointer
// modulo the ring length. The store has one write and one read port.
// ----------------------------------------------------------------------------
module multichannel_rewind_ring_buffer #(
   parameter int DEPTH        = 4096,
   parameter int CHANNELS     = 2,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rmb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rmb_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [11:0]      csr_wr_data
);

   rmb_pkg::queue_head_type head;
   logic                    cmd_pop;
   logic                    clear_busy;

   // Accept and classify
   rmb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .clear_busy (clear_busy),
      .head       (head),
      .cmd_pop    (cmd_pop)
   );

   // Execute and report
   rmb_back #(
      .DEPTH        (DEPTH),
      .CHANNELS     (CHANNELS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .cmd_pop     (cmd_pop),
      .clear_busy  (clear_busy),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// File: tb/sv/multichannel_rewind_ring_buffer_tb.sv
// ----------------------------------------------------------------------------
// multichannel_rewind_ring_buffer_tb
// Self-checking bench for the rewind ring buffer. Directed tests cover sample
// extremes, full-ring refusal and overwrite, every seek kind, zero capacity
// and the unused op codes. Random traffic then runs over several capacities.
// A local model of the ring predicts one result per accepted item. The
// sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module multichannel_rewind_ring_buffer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH   = 4096;
   localparam int BANKS        = 2;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 105;
   localparam int REPORT_MAX   = 10;

   // Op codes the block ignores
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   typedef enum logic [1:0] {READY_ON, READY_COIN, READY_OFF} ready_mode_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   rmb_pkg::req_type req_data    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rmb_pkg::rsp_type rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [11:0]      csr_wr_data = '0;

   // Ring model state
   bit [31:0]   bank_mem [BANKS][RING_DEPTH];
   int unsigned ring_cap   = 4095;
   int unsigned ring_begin = 0;
   int unsigned ring_end   = 0;
   int unsigned ring_read  = 0;

   rmb_pkg::rsp_type ring_expect[$];
   int unsigned mismatches  = 0;
   int unsigned result_idx  = 0;
   int unsigned cycle_count = 0;
   int unsigned sender_burst = 0;
   int unsigned ready_run    = 0;
   ready_mode_type ready_mode = READY_ON;

   multichannel_rewind_ring_buffer #(
      .DEPTH        (RING_DEPTH),
      .CHANNELS     (BANKS),
      .SAMPLE_WIDTH (32)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Distance from b forward to a on a ring of length len
   function automatic int unsigned ring_dist(input int unsigned a, input int unsigned b,
                                             input int unsigned len);
      return (a + len - b) % len;
   endfunction

   // Apply one item to the ring model and return its result
   function automatic rmb_pkg::rsp_type ring_predict(input rmb_pkg::req_type item);
      rmb_pkg::rsp_type r;
      int unsigned len;
      int unsigned used;
      int unsigned space;
      int unsigned roff;
      int unsigned frac;
      len = (ring_cap + 1 > RING_DEPTH) ? RING_DEPTH : ring_cap + 1;
      r = '0;
      r.burst_end = item.burst_last;
      ring_begin = ring_begin % len;
      ring_end   = ring_end % len;
      ring_read  = ring_read % len;
      case (item.op)
         rmb_pkg::OP_WRITE: begin
            space = len - ring_dist(ring_end, ring_begin, len) - 1;
            if (space >= 1 || item.overwrite) begin
               roff = ring_dist(ring_read, ring_begin, len);
               bank_mem[item.channel][ring_end] = item.sample;
               ring_end = (ring_end + 1) % len;
               // nearly full or full: begin follows end, read dragged if at begin
               if (space <= 1) begin
                  ring_begin = (ring_end + 1) % len;
                  if (space == 0 && roff == 0) ring_read = ring_begin;
               end
               r.write_accepted = 1'b1;
            end
         end
         rmb_pkg::OP_READ: begin
            if (ring_read != ring_end) begin
               r.sample_out   = bank_mem[item.channel][ring_read];
               r.sample_valid = 1'b1;
               ring_read = (ring_read + 1) % len;
            end
         end
         rmb_pkg::OP_SEEK_RD: ring_read = (ring_read + item.offset) % len;
         rmb_pkg::OP_SEEK_WR: ring_end = (ring_end + item.offset) % len;
         rmb_pkg::OP_SEEK_FRAC: begin
            frac = (item.fraction > rmb_pkg::FRAC_ONE) ? rmb_pkg::FRAC_ONE : item.fraction;
            used = ring_dist(ring_end, ring_begin, len);
            ring_read = ring_begin + int'((longint'(used) * frac) >> 16);
            if (ring_read >= len) ring_read = ring_read - len;
         end
         default: ;
      endcase
      used = ring_dist(ring_end, ring_begin, len);
      r.used_space  = used[11:0];
      space = len - used - 1;
      r.free_space  = space[11:0];
      roff = ring_dist(ring_read, ring_begin, len);
      r.read_offset = roff[11:0];
      return r;
   endfunction

   function automatic rmb_pkg::req_type make_item(input logic [2:0] op, input logic channel,
                                         input logic [31:0] sample, input logic overwrite,
                                         input logic [11:0] offset,
                                         input logic [16:0] fraction, input logic last);
      rmb_pkg::req_type item;
      item.op         = op;
      item.channel    = channel;
      item.sample     = sample;
      item.overwrite  = overwrite;
      item.offset     = offset;
      item.fraction   = fraction;
      item.burst_last = last;
      return item;
   endfunction

   // Random item: mostly writes and reads, some seeks, a few ignored codes
   function automatic rmb_pkg::req_type random_item();
      rmb_pkg::req_type item;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 38)      item.op = rmb_pkg::OP_WRITE;
      else if (pick < 76) item.op = rmb_pkg::OP_READ;
      else if (pick < 84) item.op = rmb_pkg::OP_SEEK_RD;
      else if (pick < 90) item.op = rmb_pkg::OP_SEEK_WR;
      else if (pick < 96) item.op = rmb_pkg::OP_SEEK_FRAC;
      else                item.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      item.channel   = 1'($urandom_range(0, 1));
      item.sample    = $urandom;
      item.overwrite = ($urandom_range(0, 3) != 0);
      item.offset    = 12'($urandom_range(0, 4095));
      pick = $urandom_range(0, 7);
      if (pick == 0)      item.fraction = 17'($urandom_range(65537, 131071));
      else if (pick == 1) item.fraction = rmb_pkg::FRAC_ONE;
      else if (pick == 2) item.fraction = '0;
      else                item.fraction = 17'($urandom_range(0, 65535));
      item.burst_last = 1'($urandom_range(0, 1));
      return item;
   endfunction

   // Send one item; the sender idles between bursts of random length
   task automatic send_item(input rmb_pkg::req_type item);
      int unsigned gap;
      if (sender_burst == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         sender_burst = $urandom_range(1, 20);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      sender_burst = sender_burst - 1;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      ring_expect.push_back(ring_predict(item));
   endtask

   // Capacity write once every result is back
   task automatic write_capacity(input logic [11:0] cap);
      req_valid <= 1'b0;
      while (ring_expect.size() != 0 || !req_ready) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      ring_cap   = cap;
      ring_begin = 0;
      ring_end   = 0;
      ring_read  = 0;
   endtask

   // Receiver ready pattern: runs of ready, coin flips and short stalls
   always @(posedge clock) begin
      if (ready_run == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         ready_run  = (ready_mode == READY_OFF) ? $urandom_range(1, 8) : $urandom_range(1, 40);
      end
      ready_run = ready_run - 1;
      case (ready_mode)
         READY_ON:   rsp_ready <= 1'b1;
         READY_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         default:    rsp_ready <= 1'b0;
      endcase
   end

   // Result checker
   always @(posedge clock) begin : check_results
      rmb_pkg::rsp_type exp_rsp;
      if (rsp_valid && rsp_ready) begin
         if (ring_expect.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_MAX)
               $display("result %0d arrived with nothing expected: %p", result_idx, rsp_data);
         end else begin
            exp_rsp = ring_expect.pop_front();
            if (rsp_data.sample_out !== exp_rsp.sample_out ||
                rsp_data.sample_valid !== exp_rsp.sample_valid ||
                rsp_data.write_accepted !== exp_rsp.write_accepted ||
                rsp_data.used_space !== exp_rsp.used_space ||
                rsp_data.free_space !== exp_rsp.free_space ||
                rsp_data.read_offset !== exp_rsp.read_offset ||
                rsp_data.burst_end !== exp_rsp.burst_end) begin
               mismatches = mismatches + 1;
               if (mismatches <= REPORT_MAX) begin
                  $display("result %0d mismatch", result_idx);
                  $display("  expected out=%h valid=%b acc=%b used=%0d free=%0d roff=%0d end=%b",
                           exp_rsp.sample_out, exp_rsp.sample_valid, exp_rsp.write_accepted,
                           exp_rsp.used_space, exp_rsp.free_space, exp_rsp.read_offset,
                           exp_rsp.burst_end);
                  $display("  actual   out=%h valid=%b acc=%b used=%0d free=%0d roff=%0d end=%b",
                           rsp_data.sample_out, rsp_data.sample_valid, rsp_data.write_accepted,
                           rsp_data.used_space, rsp_data.free_space, rsp_data.read_offset,
                           rsp_data.burst_end);
               end
            end
         end
         result_idx = result_idx + 1;
      end
   end

   // Sample extremes on both banks, read past the data, ignored op codes
   task automatic test_write_read();
      write_capacity(12'd4095);
      send_item(make_item(rmb_pkg::OP_WRITE, 1'b0, 32'h0000_0000, 1'b0, 12'd0, 17'd0, 1'b0));
      send_item(make_item(rmb_pkg::OP_WRITE, 1'b1, 32'hFFFF_FFFF, 1'b1, 12'hFFF, 17'h1FFFF,
                          1'b1));
      send_item(make_item(rmb_pkg::OP_WRITE, 1'b0, 32'hA5A5_5A5A, 1'b0, 12'd0, 17'd0, 1'b0));
      send_item(make_item(rmb_pkg::OP_READ, 1'b0, 32'hFFFF_FFFF, 1'b1, 12'hFFF, 17'd0, 1'b1));
      send_item(make_item(rmb_pkg::OP_READ, 1'b1, 32'd0, 1'b0, 12'd0, 17'd0, 1'b0));
      send_item(make_item(rmb_pkg::OP_READ, 1'b0, 32'd0, 1'b0, 12'd0, 17'd0, 1'b1));
      send_item(make_item(rmb_pkg::OP_READ, 1'b1, 32'd0, 1'b0, 12'd0, 17'd0, 1'b0));
      send_item(make_item(OP_UNUSED_LO, 1'b1, 32'hFFFF_FFFF, 1'b1, 12'hFFF, 17'h1FFFF, 1'b1));
      send_item(make_item(OP_UNUSED_HI, 1'b0, 32'h1234_5678, 1'b1, 12'd7, 17'd3, 1'b0));
   endtask

   // Fill a short ring, refused write, overwrite dragging the read pointer
   task automatic test_full_ring();
      write_capacity(12'd3);
      send_item(make_item(rmb_pkg::OP_WRITE, 1'b0, 32'h0000_0011, 1'b0, 12'd0, 17'd0, 1'b0));
      send_item(make_item(rmb_pkg::OP_WRITE, 1'b0, 32'h0000_0022, 1'b0, 12'd0, 17'd0, 1'b0));
      send_item(make_item(rmb_pkg::OP_WRITE, 1'b0, 32'h0000_0033, 1'b0, 12'd0, 17'd0, 1'b0));
      send_item(make_item(rmb_pkg::OP_WRITE, 1'b0, 32'h0000_0044, 1'b0, 12'd0, 17'd0, 1'b1));
      send_item(make_item(rmb_pkg::OP_WRITE, 1'b0, 32'h0000_0055, 1'b1, 12'd0, 17'd0, 1'b1));
      send_item(make_item(rmb_pkg::OP_READ, 1'b0, 32'd0, 1'b0, 12'd0, 17'd0, 1'b0));
      send_item(make_item(rmb_pkg::OP_READ, 1'b0, 32'd0, 1'b0, 12'd0, 17'd0, 1'b0));
   endtask

   // Read seek past the ring length, write seek by zero, fraction seeks incl. above one
   task automatic test_seeks();
      send_item(make_item(rmb_pkg::OP_SEEK_RD, 1'b0, 32'd0, 1'b0, 12'hFFF, 17'd0, 1'b0));
      send_item(make_item(rmb_pkg::OP_SEEK_WR, 1'b0, 32'd0, 1'b0, 12'd0, 17'd0, 1'b1));
      send_item(make_item(rmb_pkg::OP_SEEK_FRAC, 1'b0, 32'd0, 1'b0, 12'd0, 17'd0, 1'b0));
      send_item(make_item(rmb_pkg::OP_SEEK_FRAC, 1'b0, 32'd0, 1'b0, 12'd0,
                          rmb_pkg::FRAC_ONE, 1'b0));
      send_item(make_item(rmb_pkg::OP_SEEK_FRAC, 1'b1, 32'd0, 1'b0, 12'd0, 17'h1FFFF, 1'b1));
      send_item(make_item(rmb_pkg::OP_SEEK_FRAC, 1'b0, 32'd0, 1'b0, 12'd0, 17'h0_8000, 1'b0));
   endtask

   // Zero capacity: nothing held, overwrite still stores
   task automatic test_capacity_zero();
      write_capacity(12'd0);
      send_item(make_item(rmb_pkg::OP_WRITE, 1'b1, 32'hDEAD_BEEF, 1'b0, 12'd0, 17'd0, 1'b0));
      send_item(make_item(rmb_pkg::OP_WRITE, 1'b1, 32'hCAFE_F00D, 1'b1, 12'd0, 17'd0, 1'b1));
      send_item(make_item(rmb_pkg::OP_READ, 1'b1, 32'd0, 1'b0, 12'd0, 17'd0, 1'b0));
      send_item(make_item(rmb_pkg::OP_SEEK_FRAC, 1'b0, 32'd0, 1'b0, 12'd5,
                          rmb_pkg::FRAC_ONE, 1'b0));
   endtask

   // Random traffic over tiny, small, full-size and mid capacities
   task automatic test_random_traffic();
      logic [11:0] phase_cap [6];
      phase_cap[0] = 12'd1;
      phase_cap[1] = 12'd2;
      phase_cap[2] = 12'($urandom_range(3, 9));
      phase_cap[3] = 12'd4095;
      phase_cap[4] = 12'($urandom_range(10, 64));
      phase_cap[5] = 12'($urandom_range(100, 4094));
      foreach (phase_cap[p]) begin
         write_capacity(phase_cap[p]);
         repeat (PHASE_ITEMS) send_item(random_item());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_write_read();
      test_full_ring();
      test_seeks();
      test_capacity_zero();
      test_random_traffic();
      req_valid <= 1'b0;
      while (ring_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && ring_expect.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/rmb_pkg.sv
rtl/rmb_front.sv
rtl/rmb_back.sv
rtl/multichannel_rewind_ring_buffer.sv
tb/sv/multichannel_rewind_ring_buffer_tb.sv
